>>> hw/rtl/gpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpf_pkg
// Shared widths, byte codes and sequencer states of the paragraph fill block.
// ----------------------------------------------------------------------------
package gpf_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LineW = 9;

  // byte codes seen on the text stream
  localparam logic [ByteW-1:0] CharNul    = 8'h00;
  localparam logic [ByteW-1:0] CharTab    = 8'h09;
  localparam logic [ByteW-1:0] CharLf     = 8'h0A;
  localparam logic [ByteW-1:0] CharCr     = 8'h0D;
  localparam logic [ByteW-1:0] CharSpace  = 8'h20;
  localparam logic [ByteW-1:0] CharPeriod = 8'h2E;

  // utf-8 continuation bytes match 10xxxxxx
  localparam logic [ByteW-1:0] Utf8Mask = 8'hC0;
  localparam logic [ByteW-1:0] Utf8Cont = 8'h80;

  localparam logic [ByteW-1:0] FillColReset = 8'd72;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE    = 7'b000_0001,
    S_DECIDE  = 7'b000_0010,
    S_SEP     = 7'b000_0100,
    S_WRD_RD  = 7'b000_1000,
    S_WRD_OUT = 7'b001_0000,
    S_EXTRA   = 7'b010_0000,
    S_CLOSE   = 7'b100_0000
  } gpf_state_e;

endpackage

>>> hw/rtl/gpf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpf stream interfaces
// Valid/ready channels for paragraph text in and filled text out.
// ----------------------------------------------------------------------------

// text channel: one byte of paragraph text per item
interface gpf_in_if import gpf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             para_last;

  modport source (output valid, output text_byte, output para_last, input ready);
  modport sink   (input valid, input text_byte, input para_last, output ready);
endinterface

// filled channel: one output byte per item
interface gpf_out_if import gpf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             run_last;
  logic             para_done;
  logic             word_clipped;

  modport source (output valid, output out_byte, output run_last, output para_done,
                  output word_clipped, input ready);
  modport sink   (input valid, input out_byte, input run_last, input para_done,
                  input word_clipped, output ready);
endinterface

>>> hw/rtl/greedy_paragraph_fill_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_paragraph_fill_core
// Greedy paragraph filler: buffers words, emits them with space or newline
// separators against a programmable fill column.
// ----------------------------------------------------------------------------
// A text byte is taken only in the idle state, where it is stored, dropped
// or otherwise produces nothing. A byte that closes a word (blank or
// paragraph end) starts the sequencer: a decision state, a separator state,
// a word buffer read state and an output register load state per word byte,
// a state for the extra space after a word with a period and one for the
// closing newline, each output state waiting while the output register is
// full and not taken. A blank with no word pending passes only through the
// decision state. The word buffer's single registered read port is why each
// word byte needs both a read and a load state. No text is taken while the
// sequencer runs. fill_column may be written only while idle.
// ----------------------------------------------------------------------------
module greedy_paragraph_fill_core import gpf_pkg::*; #(
  parameter int unsigned WORD_BYTES = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  gpf_in_if.sink           text_i,
  gpf_out_if.source        fill_o
);

  localparam int unsigned FillW = $clog2(WORD_BYTES + 1);
  localparam int unsigned IdxW  = $clog2(WORD_BYTES);

  gpf_state_e state_q, state_d;

  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] cols_q, cols_d;
  logic             period_q, period_d;
  logic             ovf_q, ovf_d;
  logic [LineW-1:0] line_q, line_d;
  logic             started_q, started_d;
  logic             close_q, close_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [ByteW-1:0] fillcol_q;
  logic [ByteW-1:0] rd_q;
  logic [ByteW-1:0] mem [WORD_BYTES];

  logic             out_vld_q, out_vld_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             out_done_q, out_done_d;
  logic             out_clip_q, out_clip_d;

  logic             accept;
  logic             is_drop;
  logic             is_blank;
  logic             store_ok;
  logic             slot_free;
  logic             at_end;
  logic [LineW-1:0] add_op;
  logic [LineW-1:0] line_sum;
  logic [LineW:0]   tentative;

  // input classification
  assign accept    = text_i.valid && text_i.ready;
  assign is_drop   = (text_i.text_byte == CharNul) || (text_i.text_byte == CharCr);
  assign is_blank  = (text_i.text_byte == CharSpace) || (text_i.text_byte == CharTab) ||
                     (text_i.text_byte == CharLf);
  assign store_ok  = !is_drop && !is_blank && (fill_q < FillW'(WORD_BYTES));
  assign slot_free = !out_vld_q || fill_o.ready;
  assign at_end    = (FillW'(idx_q) + FillW'(1)) == fill_q;

  // shared line column adder
  always_comb begin
    add_op = LineW'(1);
    if (state_q == S_WRD_OUT) begin
      add_op = LineW'(cols_q);
    end
  end
  assign line_sum  = line_q + add_op;
  assign tentative = (LineW + 1)'(line_q) + (LineW + 1)'(cols_q) +
                     (LineW + 1)'(period_q) + (LineW + 1)'(1);

  // sequencer and word state
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    cols_d     = cols_q;
    period_d   = period_q;
    ovf_d      = ovf_q;
    line_d     = line_q;
    started_d  = started_q;
    close_d    = close_q;
    idx_d      = idx_q;
    out_vld_d  = out_vld_q && !fill_o.ready;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    out_done_d = out_done_q;
    out_clip_d = out_clip_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (store_ok) begin
            fill_d = fill_q + FillW'(1);
            if ((text_i.text_byte & Utf8Mask) != Utf8Cont) begin
              cols_d = cols_q + FillW'(1);
            end
            if (text_i.text_byte == CharPeriod) begin
              period_d = 1'b1;
            end
          end else if (!is_drop && !is_blank) begin
            ovf_d = 1'b1;
          end
          close_d = text_i.para_last;
          if (is_blank || text_i.para_last) begin
            state_d = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        idx_d = '0;
        if (fill_q != '0) begin
          state_d = started_q ? S_SEP : S_WRD_RD;
        end else begin
          ovf_d   = 1'b0;
          state_d = close_q ? S_CLOSE : S_IDLE;
        end
      end
      S_SEP: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_last_d = 1'b0;
          out_done_d = 1'b0;
          out_clip_d = 1'b0;
          if (tentative > (LineW + 1)'(fillcol_q)) begin
            out_byte_d = CharLf;
            line_d     = '0;
          end else begin
            out_byte_d = CharSpace;
            line_d     = line_sum;
          end
          state_d = S_WRD_RD;
        end
      end
      S_WRD_RD: begin
        state_d = S_WRD_OUT;
      end
      S_WRD_OUT: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_byte_d = rd_q;
          out_done_d = 1'b0;
          out_clip_d = ovf_q;
          out_last_d = at_end && !period_q && !close_q;
          if (at_end) begin
            line_d    = line_sum;
            started_d = 1'b1;
            if (period_q) begin
              state_d = S_EXTRA;
            end else begin
              fill_d  = '0;
              cols_d  = '0;
              ovf_d   = 1'b0;
              state_d = close_q ? S_CLOSE : S_IDLE;
            end
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = S_WRD_RD;
          end
        end
      end
      S_EXTRA: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_byte_d = CharSpace;
          out_done_d = 1'b0;
          out_clip_d = 1'b0;
          out_last_d = !close_q;
          line_d     = line_sum;
          fill_d     = '0;
          cols_d     = '0;
          period_d   = 1'b0;
          ovf_d      = 1'b0;
          state_d    = close_q ? S_CLOSE : S_IDLE;
        end
      end
      S_CLOSE: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_byte_d = CharLf;
          out_done_d = 1'b1;
          out_clip_d = 1'b0;
          out_last_d = 1'b1;
          line_d     = '0;
          started_d  = 1'b0;
          close_d    = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      cols_q    <= '0;
      period_q  <= 1'b0;
      ovf_q     <= 1'b0;
      line_q    <= '0;
      started_q <= 1'b0;
      close_q   <= 1'b0;
      idx_q     <= '0;
      fillcol_q <= FillColReset;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      cols_q    <= cols_d;
      period_q  <= period_d;
      ovf_q     <= ovf_d;
      line_q    <= line_d;
      started_q <= started_d;
      close_q   <= close_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        fillcol_q <= cfg_wdata_i;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
    out_clip_q <= out_clip_d;
  end

  // word buffer, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (accept && store_ok) begin
      mem[fill_q[IdxW-1:0]] <= text_i.text_byte;
    end
    if (state_q == S_WRD_RD) begin
      rd_q <= mem[idx_q];
    end
  end

  assign text_i.ready        = (state_q == S_IDLE);
  assign fill_o.valid        = out_vld_q;
  assign fill_o.out_byte     = out_byte_q;
  assign fill_o.run_last     = out_last_q;
  assign fill_o.para_done    = out_done_q;
  assign fill_o.word_clipped = out_clip_q;

  // word buffer never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(WORD_BYTES))
    else $error("word fill beyond buffer");

  // paragraph end is a newline that closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_o.valid && fill_o.para_done) |->
      (fill_o.out_byte == CharLf) && fill_o.run_last)
    else $error("para_done on wrong result");

  // clipped flag only rides on word bytes, never on blanks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_o.valid && fill_o.word_clipped) |->
      (fill_o.out_byte != CharSpace) && (fill_o.out_byte != CharLf))
    else $error("clipped flag on separator");

  // closing newline resets line position and paragraph start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLOSE && slot_free) |=> (line_q == '0) && !started_q)
    else $error("line state not cleared at paragraph end");

  // a word is only read out when it holds bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRD_RD) |-> (fill_q != '0))
    else $error("read of empty word");

endmodule
